[sv/rdh_pkg.sv]
// Shared types and constants for the run-length frame to line-command decoder.
// Used by rdh_ctrl, rdh_datapath and the top level; depends on nothing.
`default_nettype none

package rdh_pkg;

    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 64;

    // lines one run may emit before the frame-done command is held over
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_COLOR = 3'd5;

    // header bits 7..6
    localparam logic [1:0] TYPE_BITMAP = 2'b00;
    localparam logic [1:0] TYPE_DELTA  = 2'b10;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_UNSUP = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_RUN    = 2'd1,
        PH_CONT   = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    localparam logic [1:0] COLOR_BG = 2'd0;
    localparam logic [1:0] COLOR_FG = 2'd1;

    typedef struct packed {
        logic load;       // latch the accepted byte
        logic emit_owed;  // send the held-over frame-done command
        logic decode;     // header, run or continuation byte
        logic prep;       // start of a run: wrap column, clear line count
        logic seg_step;   // one row segment of the run
        logic run_close;  // frame end check after the last segment
    } t_dp_cmd;

    typedef struct packed {
        logic owed_pending;
        logic out_free;
        logic dec_emits;
        logic dec_finish;
        logic seg_active;
        logic seg_emits;
        logic close_emits;
    } t_dp_status;

endpackage

`default_nettype wire

[sv/rdh_ctrl.sv]
// Sequencer for the line-command decoder: steps one byte through decode and
// run splitting. Depends on rdh_pkg for the command and status structs.
`default_nettype none

module rdh_ctrl (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_frame_valid,
    output logic                     o_frame_stall,
    input  wire rdh_pkg::t_dp_status i_status,
    output rdh_pkg::t_dp_cmd         o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_OWED   = 6'b000010,
        S_DECODE = 6'b000100,
        S_PREP   = 6'b001000,
        S_SEG    = 6'b010000,
        S_CLOSE  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_frame_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_frame_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = i_status.owed_pending ? S_OWED : S_DECODE;
                end
            end
            S_OWED: begin
                if (i_status.out_free) begin
                    o_cmd.emit_owed = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_status.dec_emits || i_status.out_free) begin
                    o_cmd.decode = 1'b1;
                    n_state = i_status.dec_finish ? S_PREP : S_IDLE;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = S_SEG;
            end
            S_SEG: begin
                if (!i_status.seg_active) begin
                    n_state = S_CLOSE;
                end else if (!i_status.seg_emits || i_status.out_free) begin
                    o_cmd.seg_step = 1'b1;
                end
            end
            S_CLOSE: begin
                if (!i_status.close_emits || i_status.out_free) begin
                    o_cmd.run_close = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[sv/rdh_datapath.sv]
// Datapath of the line-command decoder: configuration registers, decode state,
// run splitting arithmetic and the output register. Depends on rdh_pkg.
`default_nettype none

module rdh_datapath #(
    parameter int MAX_WIDTH  = rdh_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rdh_pkg::MAX_HEIGHT_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [rdh_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [rdh_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    input  wire  [7:0]                       i_frame_byte,
    input  wire                              i_frame_start,
    input  wire rdh_pkg::t_dp_cmd            i_cmd,
    output wire rdh_pkg::t_dp_status         o_status,
    input  wire                              i_cmd_stall,
    output logic                             o_cmd_valid,
    output logic [1:0]                       o_kind,
    output logic signed [15:0]               o_pos_x,
    output logic signed [15:0]               o_pos_y,
    output logic [7:0]                       o_seg_length,
    output logic [15:0]                      o_seg_color,
    output logic                             o_last
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int W_W   = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
    localparam int CNT_W = rdh_pkg::CNT_W;

    // configuration
    logic [7:0]  r_frame_width;
    logic [6:0]  r_frame_height;
    logic [15:0] r_origin_x;
    logic [15:0] r_origin_y;
    logic [15:0] r_draw_color;
    logic [15:0] r_background_color;

    // latched byte
    logic [7:0] r_byte;
    logic       r_start;

    // decode state
    rdh_pkg::t_phase   r_phase, n_phase;
    logic              r_delta, n_delta;
    logic [1:0]        r_prior, n_prior;
    logic [1:0]        r_run_color, n_run_color;
    logic [15:0]       r_run_len, n_run_len;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_owed, n_owed;
    logic [CNT_W-1:0]  r_count, n_count;

    // output register
    logic              r_out_valid, n_out_valid;
    rdh_pkg::t_kind    r_kind, n_kind;
    logic [15:0]       r_pos_x, n_pos_x;
    logic [15:0]       r_pos_y, n_pos_y;
    logic [7:0]        r_seg_length, n_seg_length;
    logic [15:0]       r_seg_color, n_seg_color;
    logic              r_last, n_last;

    // effective geometry
    logic [W_W-1:0]   w;
    logic [ROW_W-1:0] h;

    // byte decode
    logic [1:0] hdr_type;
    logic       is_run_phase;
    logic [2:0] delta_sum;
    logic [1:0] delta_color;

    // segment arithmetic
    logic [W_W-1:0]   col_x;
    logic [W_W-1:0]   room;
    logic [W_W-1:0]   seg;
    logic [W_W-1:0]   col_sum;
    logic             seg_wrap;
    logic [ROW_W-1:0] seg_row;
    logic [COL_W-1:0] seg_col;
    logic [15:0]      seg_left;
    logic             seg_more;
    logic             seg_done_next;
    logic             visible;
    logic             frame_end;

    always_comb begin
        if (r_frame_width == 8'd0) begin
            w = W_W'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w = W_W'(MAX_WIDTH);
        end else begin
            w = W_W'(r_frame_width);
        end
        if (r_frame_height == 7'd0) begin
            h = ROW_W'(1);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            h = ROW_W'(MAX_HEIGHT);
        end else begin
            h = ROW_W'(r_frame_height);
        end
    end

    assign hdr_type     = r_byte[7:6];
    assign is_run_phase = (r_phase == rdh_pkg::PH_RUN) || (r_phase == rdh_pkg::PH_CONT);

    // prior + step + 1 is at most 5, so one conditional subtract gives mod 3
    assign delta_sum   = 3'(r_prior) + 3'(r_byte[6]) + 3'd1;
    assign delta_color = (delta_sum >= 3'd3) ? 2'(delta_sum - 3'd3) : 2'(delta_sum);

    assign col_x    = W_W'(r_col);
    assign room     = w - col_x;
    assign seg      = (r_run_len < 16'(room)) ? W_W'(r_run_len) : room;
    assign col_sum  = col_x + seg;
    assign seg_wrap = (col_sum >= w);
    assign seg_row  = seg_wrap ? r_row + ROW_W'(1) : r_row;
    assign seg_col  = seg_wrap ? '0 : COL_W'(col_sum);
    assign seg_left = r_run_len - 16'(seg);
    assign seg_more = (seg_left != 16'd0) && (seg_row < h);
    // this line counts as one, so the done command still fits below the cap
    assign seg_done_next = (seg_row >= h) && (r_count < CNT_W'(rdh_pkg::MAX_RESULTS - 1));
    assign visible   = (r_run_color == rdh_pkg::COLOR_FG)
                    || (r_delta && (r_run_color == rdh_pkg::COLOR_BG));
    assign frame_end = (r_row >= h);

    assign o_status.owed_pending = (r_phase == rdh_pkg::PH_DONE) && r_owed;
    assign o_status.out_free     = !r_out_valid || !i_cmd_stall;
    assign o_status.dec_emits    = r_start && (hdr_type != rdh_pkg::TYPE_DELTA);
    assign o_status.dec_finish   = !r_start && is_run_phase && !r_byte[7];
    assign o_status.seg_active   = (r_run_len != 16'd0) && (r_row < h);
    assign o_status.seg_emits    = visible;
    assign o_status.close_emits  = frame_end && (r_count < CNT_W'(rdh_pkg::MAX_RESULTS));

    always_comb begin
        n_phase      = r_phase;
        n_delta      = r_delta;
        n_prior      = r_prior;
        n_run_color  = r_run_color;
        n_run_len    = r_run_len;
        n_col        = r_col;
        n_row        = r_row;
        n_owed       = r_owed;
        n_count      = r_count;
        n_out_valid  = r_out_valid && i_cmd_stall;
        n_kind       = r_kind;
        n_pos_x      = r_pos_x;
        n_pos_y      = r_pos_y;
        n_seg_length = r_seg_length;
        n_seg_color  = r_seg_color;
        n_last       = r_last;

        if (i_cmd.emit_owed) begin
            n_owed       = 1'b0;
            n_out_valid  = 1'b1;
            n_kind       = rdh_pkg::KIND_DONE;
            n_pos_x      = '0;
            n_pos_y      = '0;
            n_seg_length = '0;
            n_seg_color  = '0;
            // a header other than delta emits behind it
            n_last       = !(r_start && (hdr_type != rdh_pkg::TYPE_DELTA));
        end

        if (i_cmd.decode) begin
            if (r_start) begin
                n_col       = '0;
                n_row       = '0;
                n_run_len   = '0;
                n_run_color = '0;
                if (hdr_type == rdh_pkg::TYPE_BITMAP) begin
                    n_phase      = rdh_pkg::PH_HEADER;
                    n_delta      = 1'b0;
                    n_prior      = '0;
                    n_out_valid  = 1'b1;
                    n_kind       = rdh_pkg::KIND_UNSUP;
                    n_pos_x      = '0;
                    n_pos_y      = '0;
                    n_seg_length = '0;
                    n_seg_color  = '0;
                    n_last       = 1'b1;
                end else begin
                    n_phase = rdh_pkg::PH_RUN;
                    n_delta = (hdr_type == rdh_pkg::TYPE_DELTA);
                    n_prior = r_byte[1:0];
                    if (hdr_type != rdh_pkg::TYPE_DELTA) begin
                        n_out_valid  = 1'b1;
                        n_kind       = rdh_pkg::KIND_CLEAR;
                        n_pos_x      = r_origin_x;
                        n_pos_y      = r_origin_y;
                        n_seg_length = '0;
                        n_seg_color  = r_background_color;
                        n_last       = 1'b1;
                    end
                end
            end else if (r_phase == rdh_pkg::PH_RUN) begin
                if (r_delta) begin
                    n_run_color = delta_color;
                    n_run_len   = 16'(r_byte[5:0]);
                end else begin
                    n_run_color = 2'd1 - r_prior;
                    n_run_len   = 16'(r_byte[6:0]);
                end
                if (r_byte[7]) begin
                    n_phase = rdh_pkg::PH_CONT;
                end
            end else if (r_phase == rdh_pkg::PH_CONT) begin
                n_run_len = {r_run_len[8:0], r_byte[6:0]};
            end
        end

        if (i_cmd.prep) begin
            n_prior = r_run_color;
            n_count = '0;
            if (col_x >= w) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end
        end

        if (i_cmd.seg_step) begin
            n_col     = seg_col;
            n_row     = seg_row;
            n_run_len = seg_left;
            if (visible) begin
                n_count      = r_count + CNT_W'(1);
                n_out_valid  = 1'b1;
                n_kind       = rdh_pkg::KIND_LINE;
                n_pos_x      = r_origin_x + 16'(r_col);
                n_pos_y      = r_origin_y + 16'(r_row);
                n_seg_length = 8'(seg);
                n_seg_color  = (r_run_color == rdh_pkg::COLOR_FG) ? r_draw_color
                                                                  : r_background_color;
                n_last       = !seg_more && !seg_done_next;
            end
        end

        if (i_cmd.run_close) begin
            n_run_len = '0;
            if (frame_end) begin
                n_phase = rdh_pkg::PH_DONE;
                if (r_count < CNT_W'(rdh_pkg::MAX_RESULTS)) begin
                    n_out_valid  = 1'b1;
                    n_kind       = rdh_pkg::KIND_DONE;
                    n_pos_x      = '0;
                    n_pos_y      = '0;
                    n_seg_length = '0;
                    n_seg_color  = '0;
                    n_last       = 1'b1;
                end else begin
                    n_owed = 1'b1;
                end
            end else begin
                n_phase = rdh_pkg::PH_RUN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width      <= 8'd128;
            r_frame_height     <= 7'd64;
            r_origin_x         <= '0;
            r_origin_y         <= '0;
            r_draw_color       <= 16'd1;
            r_background_color <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rdh_pkg::REG_FRAME_WIDTH:      r_frame_width      <= i_cfg_data[7:0];
                rdh_pkg::REG_FRAME_HEIGHT:     r_frame_height     <= i_cfg_data[6:0];
                rdh_pkg::REG_ORIGIN_X:         r_origin_x         <= i_cfg_data;
                rdh_pkg::REG_ORIGIN_Y:         r_origin_y         <= i_cfg_data;
                rdh_pkg::REG_DRAW_COLOR:       r_draw_color       <= i_cfg_data;
                rdh_pkg::REG_BACKGROUND_COLOR: r_background_color <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= rdh_pkg::PH_HEADER;
            r_delta     <= 1'b0;
            r_prior     <= '0;
            r_run_color <= '0;
            r_run_len   <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_owed      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_delta     <= n_delta;
            r_prior     <= n_prior;
            r_run_color <= n_run_color;
            r_run_len   <= n_run_len;
            r_col       <= n_col;
            r_row       <= n_row;
            r_owed      <= n_owed;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte  <= i_frame_byte;
            r_start <= i_frame_start;
        end
        r_kind       <= n_kind;
        r_pos_x      <= n_pos_x;
        r_pos_y      <= n_pos_y;
        r_seg_length <= n_seg_length;
        r_seg_color  <= n_seg_color;
        r_last       <= n_last;
    end

    assign o_cmd_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_pos_x      = r_pos_x;
    assign o_pos_y      = r_pos_y;
    assign o_seg_length = r_seg_length;
    assign o_seg_color  = r_seg_color;
    assign o_last       = r_last;

endmodule

`default_nettype wire

[sv/rle_delta_frame_to_hlines.sv]
// Run-length frame decoder top level: controller plus datapath.
// Depends on rdh_pkg, rdh_ctrl and rdh_datapath.
//
// Takes a run-length coded monochrome frame one byte per request and returns
// clear-rectangle, horizontal-line, frame-done and unsupported-frame commands,
// with o_last set on the final command caused by each byte. One byte is taken
// at a time: a byte that ends no run is accepted and then decoded, with a
// held-over frame-done command sent in between when one is owed. A byte that
// ends a run then goes through a prepare step, one segment step per row
// segment the run covers (at most one per frame row), a step that sees the
// run is spent, and a close step.
// Every emitted command also waits for the single output register to drain,
// so a stalled consumer adds its stall cycles.
// Configuration writes are taken in any cycle and should only be made while
// no byte is in flight.
`default_nettype none

module rle_delta_frame_to_hlines #(
    parameter int MAX_WIDTH  = rdh_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rdh_pkg::MAX_HEIGHT_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [rdh_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [rdh_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    input  wire                              i_frame_valid,
    output logic                             o_frame_stall,
    input  wire  [7:0]                       i_frame_byte,
    input  wire                              i_frame_start,
    output logic                             o_cmd_valid,
    input  wire                              i_cmd_stall,
    output logic [1:0]                       o_kind,
    output logic signed [15:0]               o_pos_x,
    output logic signed [15:0]               o_pos_y,
    output logic [7:0]                       o_seg_length,
    output logic [15:0]                      o_seg_color,
    output logic                             o_last
);

    rdh_pkg::t_dp_cmd    cmd;
    rdh_pkg::t_dp_status status;

    assign o_cfg_ready = 1'b1;

    rdh_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_valid (i_frame_valid),
        .o_frame_stall (o_frame_stall),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    rdh_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_frame_byte  (i_frame_byte),
        .i_frame_start (i_frame_start),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cmd_stall   (i_cmd_stall),
        .o_cmd_valid   (o_cmd_valid),
        .o_kind        (o_kind),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_seg_length  (o_seg_length),
        .o_seg_color   (o_seg_color),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

[tb/rle_delta_frame_to_hlines_test.sv]
// Self-checking testbench for the run-length frame to line-command decoder.
// Depends on rdh_pkg and rle_delta_frame_to_hlines, and through it on rdh_ctrl and rdh_datapath.
// A built-in decoder model predicts every command that each frame byte causes.
`timescale 1ns / 1ps

module rle_delta_frame_to_hlines_test;

    localparam logic [1:0] TYPE_PLAIN_LO = 2'b01;
    localparam logic [1:0] TYPE_PLAIN_HI = 2'b11;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        rdh_pkg::t_kind kind;
        logic [15:0]    x;
        logic [15:0]    y;
        logic [7:0]     len;
        logic [15:0]    color;
        logic           last;
    } t_cmd;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } t_frame_item;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [rdh_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [rdh_pkg::CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                          i_frame_valid = 1'b0;
    logic                          o_frame_stall;
    logic [7:0]                    i_frame_byte = '0;
    logic                          i_frame_start = 1'b0;
    logic                          o_cmd_valid;
    logic                          i_cmd_stall = 1'b0;
    logic [1:0]                    o_kind;
    logic signed [15:0]            o_pos_x;
    logic signed [15:0]            o_pos_y;
    logic [7:0]                    o_seg_length;
    logic [15:0]                   o_seg_color;
    logic                          o_last;

    rle_delta_frame_to_hlines DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_frame_valid (i_frame_valid),
        .o_frame_stall (o_frame_stall),
        .i_frame_byte  (i_frame_byte),
        .i_frame_start (i_frame_start),
        .o_cmd_valid   (o_cmd_valid),
        .i_cmd_stall   (i_cmd_stall),
        .o_kind        (o_kind),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_seg_length  (o_seg_length),
        .o_seg_color   (o_seg_color),
        .o_last        (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // register copies seen by the decoder model
    logic [7:0]  cfg_width = 8'd128;
    logic [6:0]  cfg_height = 7'd64;
    logic [15:0] cfg_org_x = '0;
    logic [15:0] cfg_org_y = '0;
    logic [15:0] cfg_fg = 16'd1;
    logic [15:0] cfg_bg = '0;

    // decoder model state
    rdh_pkg::t_phase dec_phase = rdh_pkg::PH_HEADER;
    logic            dec_delta = 1'b0;
    logic [1:0]      dec_prior = '0;
    logic [1:0]      dec_run_color = '0;
    logic [15:0]     dec_len = '0;
    int              dec_col = 0;
    int              dec_row = 0;

    t_cmd        step_cmds[$];
    t_cmd        pending_cmds[$];
    t_frame_item frame_bytes_q[$];

    int tx_gap_max = 0;
    int rx_gap_max = 0;
    int tx_gap = 0;
    int rx_wait = 0;
    int hold_ticket = 0;
    int hold_served = 0;
    int hold_left = 0;

    int mismatch_count = 0;
    int bytes_taken = 0;
    int reg_writes = 0;
    int n_clear = 0;
    int n_line = 0;
    int n_done = 0;
    int n_unsup = 0;

    // stimulus generator state
    logic gen_in_frame = 1'b0;
    logic gen_delta = 1'b0;
    int   gen_pixels = 0;

    int          width_edges[5]  = '{0, 1, 128, 129, 255};
    int          height_edges[5] = '{0, 1, 64, 65, 127};
    logic [15:0] word_edges[4]   = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

    t_frame_item next_item;
    int          next_gap;
    t_cmd        want;

    function automatic int frame_cols();
        if (cfg_width == 0) return 1;
        return (cfg_width > rdh_pkg::MAX_WIDTH_DEF) ? rdh_pkg::MAX_WIDTH_DEF : int'(cfg_width);
    endfunction

    function automatic int frame_rows();
        if (cfg_height == 0) return 1;
        return (cfg_height > rdh_pkg::MAX_HEIGHT_DEF) ? rdh_pkg::MAX_HEIGHT_DEF
                                                       : int'(cfg_height);
    endfunction

    function automatic void add_cmd(rdh_pkg::t_kind k, logic [15:0] x, logic [15:0] y,
                                    logic [7:0] len, logic [15:0] color);
        t_cmd c;
        c.kind  = k;
        c.x     = x;
        c.y     = y;
        c.len   = len;
        c.color = color;
        c.last  = 1'b0;
        step_cmds.push_back(c);
    endfunction

    // Cut the finished run into row segments; stop at the frame end.
    function automatic void close_run();
        int          w;
        int          h;
        int          remain;
        int          left;
        int          seg;
        logic        visible;
        logic [15:0] pix;
        w = frame_cols();
        h = frame_rows();
        visible = (dec_run_color == rdh_pkg::COLOR_FG)
               || (dec_delta && dec_run_color == rdh_pkg::COLOR_BG);
        pix = (dec_run_color == rdh_pkg::COLOR_FG) ? cfg_fg : cfg_bg;
        dec_prior = dec_run_color;
        if (dec_col >= w) begin
            dec_col = 0;
            dec_row++;
        end
        remain = (dec_row >= h) ? 0 : (h - dec_row) * w - dec_col;
        left = (int'(dec_len) < remain) ? int'(dec_len) : remain;
        while (left > 0) begin
            seg = w - dec_col;
            if (seg > left) seg = left;
            if (visible)
                add_cmd(rdh_pkg::KIND_LINE, 16'(cfg_org_x + dec_col),
                        16'(cfg_org_y + dec_row), 8'(seg), pix);
            dec_col += seg;
            if (dec_col >= w) begin
                dec_col = 0;
                dec_row++;
            end
            left -= seg;
        end
        dec_len = '0;
        if (dec_row >= h) begin
            dec_phase = rdh_pkg::PH_DONE;
            // hold the frame-done command over when the run filled the step
            if (step_cmds.size() < rdh_pkg::MAX_RESULTS)
                add_cmd(rdh_pkg::KIND_DONE, '0, '0, '0, '0);
            else dec_len = 16'd1;
        end else begin
            dec_phase = rdh_pkg::PH_RUN;
        end
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic start);
        t_cmd c;
        step_cmds.delete();
        if (dec_phase == rdh_pkg::PH_DONE && dec_len != 0) begin
            add_cmd(rdh_pkg::KIND_DONE, '0, '0, '0, '0);
            dec_len = '0;
        end
        if (start) begin
            dec_col = 0;
            dec_row = 0;
            dec_len = '0;
            dec_run_color = '0;
            if (b[7:6] == rdh_pkg::TYPE_BITMAP) begin
                add_cmd(rdh_pkg::KIND_UNSUP, '0, '0, '0, '0);
                dec_phase = rdh_pkg::PH_HEADER;
                dec_delta = 1'b0;
                dec_prior = '0;
            end else begin
                dec_delta = (b[7:6] == rdh_pkg::TYPE_DELTA);
                dec_prior = b[1:0];
                dec_phase = rdh_pkg::PH_RUN;
                if (!dec_delta)
                    add_cmd(rdh_pkg::KIND_CLEAR, cfg_org_x, cfg_org_y, '0, cfg_bg);
            end
        end else if (dec_phase == rdh_pkg::PH_RUN) begin
            if (dec_delta) begin
                dec_run_color = 2'((int'(dec_prior) + int'(b[6]) + 1) % 3);
                dec_len = 16'(b[5:0]);
            end else begin
                dec_run_color = 2'(1 - int'(dec_prior));
                dec_len = 16'(b[6:0]);
            end
            if (b[7]) dec_phase = rdh_pkg::PH_CONT;
            else close_run();
        end else if (dec_phase == rdh_pkg::PH_CONT) begin
            dec_len = (dec_len << 7) | 16'(b[6:0]);
            if (!b[7]) close_run();
        end
        if (step_cmds.size() != 0) begin
            c = step_cmds.pop_back();
            c.last = 1'b1;
            step_cmds.push_back(c);
        end
        while (step_cmds.size() != 0) pending_cmds.push_back(step_cmds.pop_front());
    endfunction

    // Frame byte driver: one request per queued byte, random gap before each.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_frame_valid <= 1'b0;
            i_frame_byte  <= '0;
            i_frame_start <= 1'b0;
            tx_gap        <= 0;
        end else if (i_frame_valid && !o_frame_stall) begin
            decode_byte(i_frame_byte, i_frame_start);
            bytes_taken++;
            next_gap = $urandom_range(0, tx_gap_max);
            if (next_gap == 0 && frame_bytes_q.size() != 0) begin
                next_item = frame_bytes_q.pop_front();
                i_frame_byte  <= next_item.data;
                i_frame_start <= next_item.start;
            end else begin
                i_frame_valid <= 1'b0;
                tx_gap        <= next_gap;
            end
        end else if (!i_frame_valid) begin
            if (tx_gap != 0) begin
                tx_gap <= tx_gap - 1;
            end else if (frame_bytes_q.size() != 0) begin
                next_item = frame_bytes_q.pop_front();
                i_frame_valid <= 1'b1;
                i_frame_byte  <= next_item.data;
                i_frame_start <= next_item.start;
            end
        end
    end

    // Long receiver hold-off, armed by the stimulus process.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left   <= 0;
            hold_served <= 0;
        end else if (hold_ticket != hold_served) begin
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_ticket;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Command monitor: check each accepted command, then stall a random while.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cmd_stall <= 1'b0;
            rx_wait     <= 0;
        end else if (o_cmd_valid && !i_cmd_stall) begin
            case (o_kind)
                rdh_pkg::KIND_CLEAR: n_clear++;
                rdh_pkg::KIND_LINE:  n_line++;
                rdh_pkg::KIND_DONE:  n_done++;
                default:             n_unsup++;
            endcase
            if (pending_cmds.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected command: kind %0d x %h y %h len %0d color %h last %0d",
                             o_kind, o_pos_x, o_pos_y, o_seg_length, o_seg_color, o_last);
            end else begin
                want = pending_cmds.pop_front();
                if (o_kind !== want.kind || o_pos_x !== want.x || o_pos_y !== want.y ||
                    o_seg_length !== want.len || o_seg_color !== want.color ||
                    o_last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("command mismatch: expected kind %0d x %h y %h len %0d color %h last %0d",
                                 want.kind, want.x, want.y, want.len, want.color, want.last);
                        $display("                  got kind %0d x %h y %h len %0d color %h last %0d",
                                 o_kind, o_pos_x, o_pos_y, o_seg_length, o_seg_color, o_last);
                    end
                end
            end
            next_gap = $urandom_range(0, rx_gap_max);
            rx_wait     <= next_gap;
            i_cmd_stall <= (next_gap != 0) || (hold_left != 0);
        end else if (rx_wait != 0) begin
            rx_wait     <= rx_wait - 1;
            i_cmd_stall <= (rx_wait > 1) || (hold_left != 0);
        end else begin
            i_cmd_stall <= (hold_left != 0);
        end
    end

    task automatic push_byte(input logic [7:0] data, input logic start);
        t_frame_item item;
        item.data  = data;
        item.start = start;
        frame_bytes_q.push_back(item);
    endtask

    // Wait until every byte is taken, the block is back at rest and every
    // command is back.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (frame_bytes_q.size() != 0 || i_frame_valid || o_frame_stall ||
               pending_cmds.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [rdh_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            rdh_pkg::REG_FRAME_WIDTH:      cfg_width  = data[7:0];
            rdh_pkg::REG_FRAME_HEIGHT:     cfg_height = data[6:0];
            rdh_pkg::REG_ORIGIN_X:         cfg_org_x  = data;
            rdh_pkg::REG_ORIGIN_Y:         cfg_org_y  = data;
            rdh_pkg::REG_DRAW_COLOR:       cfg_fg     = data;
            rdh_pkg::REG_BACKGROUND_COLOR: cfg_bg     = data;
            default: ;
        endcase
    endtask

    task automatic write_geometry(input int w, input int h, input logic [15:0] ox,
                                  input logic [15:0] oy, input logic [15:0] fg,
                                  input logic [15:0] bg);
        write_reg(rdh_pkg::REG_FRAME_WIDTH, 16'(w));
        write_reg(rdh_pkg::REG_FRAME_HEIGHT, 16'(h));
        write_reg(rdh_pkg::REG_ORIGIN_X, ox);
        write_reg(rdh_pkg::REG_ORIGIN_Y, oy);
        write_reg(rdh_pkg::REG_DRAW_COLOR, fg);
        write_reg(rdh_pkg::REG_BACKGROUND_COLOR, bg);
    endtask

    function automatic logic [15:0] pick_word();
        if ($urandom_range(0, 3) == 0) return word_edges[$urandom_range(0, 3)];
        return 16'($urandom);
    endfunction

    task automatic random_config();
        int w;
        int h;
        case ($urandom_range(0, 9))
            0:       w = width_edges[$urandom_range(0, 4)];
            1, 2:    w = $urandom_range(17, 128);
            default: w = $urandom_range(1, 16);
        endcase
        case ($urandom_range(0, 9))
            0:       h = height_edges[$urandom_range(0, 4)];
            1, 2:    h = $urandom_range(9, 64);
            default: h = $urandom_range(1, 8);
        endcase
        write_geometry(w, h, pick_word(), pick_word(), pick_word(), pick_word());
    endtask

    // Mostly well-formed frames: header, then runs sized to reach the frame
    // end in a handful of steps; some noise and stray bytes after the end.
    task automatic gen_frames(input int n_items);
        int          counted;
        int          pick;
        int          total;
        int          run_len;
        int          fmax;
        int          extra;
        logic [1:0]  hdr_type;
        logic [7:0]  b;
        logic        cbit;
        counted = 0;
        while (counted < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                push_byte(8'($urandom), 1'($urandom_range(0, 1)));
                counted++;
            end else if (!gen_in_frame || pick < 7) begin
                case ($urandom_range(0, 9))
                    0:          hdr_type = rdh_pkg::TYPE_BITMAP;
                    1, 2, 3, 4: hdr_type = rdh_pkg::TYPE_DELTA;
                    5, 6, 7:    hdr_type = TYPE_PLAIN_LO;
                    default:    hdr_type = TYPE_PLAIN_HI;
                endcase
                push_byte({hdr_type, 6'($urandom)}, 1'b1);
                counted++;
                gen_in_frame = (hdr_type != rdh_pkg::TYPE_BITMAP);
                gen_delta = (hdr_type == rdh_pkg::TYPE_DELTA);
                gen_pixels = 0;
            end else begin
                total = frame_cols() * frame_rows();
                run_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, total / 3 + 1);
                fmax = gen_delta ? 63 : 127;
                cbit = 1'($urandom_range(0, 1));
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    // long continuation chain: length overflows 16 bits
                    extra = $urandom_range(1, 3);
                    push_byte(8'($urandom) | 8'h80, 1'b0);
                    repeat (extra) push_byte(8'($urandom) | 8'h80, 1'b0);
                    push_byte(8'($urandom) & 8'h7F, 1'b0);
                    counted += extra + 2;
                    run_len = total;
                end else if (run_len <= fmax && pick < 14) begin
                    b = gen_delta ? {1'b0, cbit, 6'(run_len)} : {1'b0, 7'(run_len)};
                    push_byte(b, 1'b0);
                    counted++;
                end else begin
                    if ((run_len >> 7) > fmax) run_len = (fmax << 7) | (run_len & 127);
                    b = gen_delta ? {1'b1, cbit, 6'(run_len >> 7)} : {1'b1, 7'(run_len >> 7)};
                    push_byte(b, 1'b0);
                    push_byte({1'b0, 7'(run_len)}, 1'b0);
                    counted += 2;
                end
                gen_pixels += run_len;
                if (gen_pixels >= total) begin
                    gen_in_frame = 1'b0;
                    if ($urandom_range(0, 3) == 0) push_byte(8'($urandom), 1'b0);
                end
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset geometry: stray bytes, bitmap header, a short delta frame
        tx_gap_max = 0;
        rx_gap_max = 13;
        push_byte(8'h55, 1'b0);
        push_byte(8'h3C, 1'b1);
        push_byte(8'h12, 1'b0);
        push_byte(8'h80, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h43, 1'b0);
        push_byte(8'h05, 1'b0);
        push_byte(8'h0A, 1'b0);
        push_byte(8'hC1, 1'b1);
        wait_idle();

        // one-pixel rows: a full-height run holds frame done over one byte
        write_geometry(0, 127, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hA5A5);
        tx_gap_max = 13;
        rx_gap_max = 0;
        push_byte(8'h40, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'h21, 1'b0);
        push_byte(8'h21, 1'b0);
        push_byte(8'h43, 1'b1);
        push_byte(8'h80, 1'b0);
        push_byte(8'hC0, 1'b0);
        push_byte(8'h00, 1'b0);
        wait_idle();

        // oversized geometry, overflowing length, owed done before a header
        write_geometry(129, 65, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
        tx_gap_max = 13;
        rx_gap_max = 13;
        push_byte(8'h80, 1'b1);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h83, 1'b1);
        push_byte(8'h40, 1'b0);
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            random_config();
            if (p == 2) begin
                tx_gap_max = 0;
                rx_gap_max = 13;
                hold_ticket++;
            end else begin
                tx_gap_max = $urandom_range(0, 1) ? 13 : 0;
                rx_gap_max = $urandom_range(0, 1) ? 13 : 0;
            end
            gen_frames(29);
            wait_idle();
        end

        if (pending_cmds.size() != 0) begin
            $display("%0d expected commands never arrived", pending_cmds.size());
            mismatch_count += pending_cmds.size();
        end
        $display("Fed %0d frame bytes; checked %0d clears, %0d lines, %0d frame ends, %0d unsupported.",
                 bytes_taken, n_clear, n_line, n_done, n_unsup);
        $display("Made %0d register writes across 11 settings, with one long output hold-off.",
                 reg_writes);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("run timed out");
        $display("FAILURE");
        $finish;
    end

endmodule
